@@ hdl/deq_pkg.sv @@
// deq_pkg: shared constants, codes and transfer types for the double-ended queue.
// No dependencies; imported by deq_ctrl, deq_dpath and double_ended_queue_top.
package deq_pkg;

  localparam int CAPACITY   = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int INDEX_W    = $clog2(CAPACITY);
  localparam int COUNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] value_in;
    logic [9:0]  offset;
  } request_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [10:0] count;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  // store index ofs places after base; both below CAPACITY
  function automatic logic [INDEX_W-1:0] ring_add(input logic [INDEX_W-1:0] base,
                                                  input logic [INDEX_W-1:0] ofs);
    logic [INDEX_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (INDEX_W+1)'(CAPACITY)) begin
      sum = sum - (INDEX_W+1)'(CAPACITY);
    end
    return sum[INDEX_W-1:0];
  endfunction

endpackage

@@ hdl/deq_ctrl.sv @@
// deq_ctrl: sequencer for one transfer at a time (load, execute, respond).
// Depends on deq_pkg; drives the datapath command struct.
module deq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output deq_pkg::dp_cmd_t cmd
);
  import deq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RESP} state_t;

  state_t state;

  always_comb begin
    cmd.load = (state == S_IDLE) && start;
    cmd.exec = (state == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            busy  <= 1'b1;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          done  <= 1'b1;
          state <= S_RESP;
        end
        S_RESP: begin
          done  <= 1'b0;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/deq_dpath.sv @@
// deq_dpath: ring store, front pointer, count and result registers.
// Depends on deq_pkg; sequenced by deq_ctrl through dp_cmd_t.
module deq_dpath (
  input  logic              clk,
  input  logic              rst,
  input  deq_pkg::dp_cmd_t  cmd,
  input  deq_pkg::request_t request,
  output deq_pkg::result_t  result
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  request_t              req;
  logic [INDEX_W-1:0]    front;
  logic [COUNT_W-1:0]    count;
  logic [1:0]            status;
  logic                  rd_ok;
  logic [DATA_WIDTH-1:0] rdata;

  logic [INDEX_W-1:0]    addr;
  logic                  we;
  logic                  re;
  logic [INDEX_W-1:0]    front_next;
  logic [COUNT_W-1:0]    count_next;
  logic [1:0]            status_next;
  logic                  full;
  logic                  empty;

  assign full  = (count >= COUNT_W'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    addr        = front;
    we          = 1'b0;
    re          = 1'b0;
    front_next  = front;
    count_next  = count;
    status_next = ST_OK;
    case (req.operation)
      OP_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          addr       = ring_add(front, INDEX_W'(count));
          we         = 1'b1;
          count_next = count + COUNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          front_next = (front == '0) ? INDEX_W'(CAPACITY - 1) : front - INDEX_W'(1);
          addr       = front_next;
          we         = 1'b1;
          count_next = count + COUNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          addr       = ring_add(front, INDEX_W'(count - COUNT_W'(1)));
          re         = 1'b1;
          count_next = count - COUNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          addr       = front;
          re         = 1'b1;
          front_next = ring_add(front, INDEX_W'(1));
          count_next = count - COUNT_W'(1);
        end
      end
      OP_READ: begin
        if (32'(req.offset) >= 32'(count)) begin
          status_next = ST_RANGE;
        end else begin
          addr = ring_add(front, INDEX_W'(req.offset));
          re   = 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
    if (cmd.exec && we) begin
      mem[addr] <= req.value_in[DATA_WIDTH-1:0];
    end
    if (cmd.exec && re) begin
      rdata <= mem[addr];
    end
    if (cmd.exec) begin
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      rd_ok <= 1'b0;
    end else if (cmd.exec) begin
      front <= front_next;
      count <= count_next;
      rd_ok <= re;
    end
  end

  assign result.value_out = rd_ok ? 32'(rdata) : 32'd0;
  assign result.count     = 11'(count);
  assign result.status    = status;

endmodule

@@ hdl/double_ended_queue_top.sv @@
// double_ended_queue_top: fixed-capacity deque in a ring store.
// Depends on deq_pkg, deq_ctrl and deq_dpath.
//
//   channel   ports                       transfer when
//   request   start, busy, request        start high and busy low
//   result    done, result                done high (one cycle, no stall)
//
// Each transfer runs load, one store access (single-port RAM with
// registered read), then the result cycle; busy is high from the store access through the result cycle.
// A new transfer is taken the cycle after done.
// Reset clears front pointer and count; store contents are not cleared.
// The result side cannot stall: done is a one-cycle strobe.
module double_ended_queue_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  deq_pkg::request_t request,
  output logic              done,
  output deq_pkg::result_t  result
);
  import deq_pkg::*;

  dp_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  deq_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .result  (result)
  );

`ifndef SYNTHESIS
  a_done_in_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done outside busy window");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transfer did not raise busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held more than one cycle");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result.count) <= 32'(CAPACITY)))
    else $error("count above capacity");
`endif

endmodule

@@ test/double_ended_queue_checker.sv @@
`timescale 1ns / 100ps
// double_ended_queue_checker: watches the request and result channels of the deque,
// keeps its own ring copy, predicts each result and compares field by field.
// Depends on deq_pkg for the transfer types, codes and sizes.
module double_ended_queue_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  deq_pkg::request_t request,
  input  logic              done,
  input  deq_pkg::result_t  result,
  output int                fails,
  output int                pending,
  output int                depth
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] contents [CAPACITY];
  int                    head;
  result_t               awaited [$];

  function automatic int ring_slot(int ofs);
    int p;
    p = head + ofs;
    if (p >= CAPACITY) begin
      p -= CAPACITY;
    end
    return p;
  endfunction

  // applies one operation to the copy and returns the result it must produce
  function automatic result_t apply_op(request_t rq);
    result_t r;
    r = '0;
    r.status = ST_OK;
    case (rq.operation)
      OP_PUSH_BACK: begin
        if (depth >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          contents[ring_slot(depth)] = rq.value_in;
          depth++;
        end
      end
      OP_PUSH_FRONT: begin
        if (depth >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          head = (head == 0) ? CAPACITY - 1 : head - 1;
          contents[head] = rq.value_in;
          depth++;
        end
      end
      OP_POP_BACK: begin
        if (depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value_out = contents[ring_slot(depth - 1)];
          depth--;
        end
      end
      OP_POP_FRONT: begin
        if (depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value_out = contents[head];
          head = ring_slot(1);
          depth--;
        end
      end
      OP_READ: begin
        if (int'(rq.offset) >= depth) begin
          r.status = ST_RANGE;
        end else begin
          r.value_out = contents[ring_slot(int'(rq.offset))];
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(depth);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      head  = 0;
      depth = 0;
      fails = 0;
      awaited.delete();
    end else begin
      if (done) begin
        if (awaited.size() == 0) begin
          fails++;
          $display("%0t: result expected none actual %h", $time, result);
        end else begin
          want = awaited.pop_front();
          check_field("value_out", want.value_out, result.value_out);
          check_field("count", want.count, result.count);
          check_field("status", want.status, result.status);
        end
      end
      if (start && !busy) begin
        awaited.push_back(apply_op(request));
      end
    end
    pending = awaited.size();
  end

endmodule

@@ test/double_ended_queue_top_test.sv @@
`timescale 1ns / 100ps
// double_ended_queue_top_test: drives directed and random deque operations in bursts
// and gives the verdict. Depends on deq_pkg, double_ended_queue_top and the checker.
module double_ended_queue_top_test;
  import deq_pkg::*;

  localparam int IDLE_LIMIT = 1000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  logic     done;
  request_t request = '0;
  result_t  result;
  int       fails;
  int       pending;
  int       depth;
  int       stall_cycles = 0;
  int       burst_left = 0;

  always #5 clk = ~clk;

  double_ended_queue_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  double_ended_queue_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .fails   (fails),
    .pending (pending),
    .depth   (depth)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles == IDLE_LIMIT) begin
      $display("double_ended_queue_top: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one transfer, with a random gap whenever a burst runs out
  task automatic send(logic [2:0] op, logic [31:0] val, logic [9:0] off);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        start   <= 1'b0;
        request <= {3'($urandom), $urandom, 10'($urandom)};
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    start   <= 1'b1;
    request <= '{operation: op, value_in: val, offset: off};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic issue_mix(int push_pct, int pop_pct, int read_pct);
    int         pick;
    logic [2:0] op;
    logic [9:0] off;
    pick = $urandom_range(0, 99);
    if (pick < push_pct) begin
      op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end else if (pick < push_pct + pop_pct) begin
      op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    end else if (pick < push_pct + pop_pct + read_pct) begin
      op = OP_READ;
    end else begin
      op = 3'(OP_READ + $urandom_range(1, 3));
    end
    if (depth == 0 || $urandom_range(0, 7) == 0) begin
      off = 10'($urandom);
    end else begin
      off = 10'($urandom_range(0, depth - 1));
    end
    send(op, $urandom, off);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty queue errors
    send(OP_POP_BACK, $urandom, 10'($urandom));
    send(OP_POP_FRONT, $urandom, 10'($urandom));
    send(OP_READ, $urandom, 10'h000);
    send(OP_READ, $urandom, 10'h3FF);
    // front pointer wraps below zero on the first push at the front
    send(OP_PUSH_BACK, 32'hFFFF_FFFF, 10'($urandom));
    send(OP_PUSH_FRONT, 32'h0000_0000, 10'($urandom));
    send(OP_PUSH_BACK, 32'h5A5A_A5A5, 10'($urandom));
    send(OP_PUSH_FRONT, 32'h8000_0001, 10'($urandom));
    send(OP_READ, $urandom, 10'h000);
    send(OP_READ, $urandom, 10'h003);
    send(OP_READ, $urandom, 10'h004);
    send(OP_READ, $urandom, 10'h3FF);
    // spare operation codes do nothing
    send(3'(OP_READ + 1), $urandom, 10'($urandom));
    send(3'(OP_READ + 2), $urandom, 10'($urandom));
    send(3'(OP_READ + 3), $urandom, 10'($urandom));
    send(OP_POP_FRONT, $urandom, 10'($urandom));
    send(OP_POP_BACK, $urandom, 10'($urandom));
    send(OP_POP_FRONT, $urandom, 10'($urandom));
    send(OP_POP_BACK, $urandom, 10'($urandom));
    send(OP_POP_BACK, $urandom, 10'($urandom));
    send(OP_POP_FRONT, $urandom, 10'($urandom));
    send(OP_PUSH_FRONT, $urandom, 10'($urandom));
    send(OP_POP_FRONT, $urandom, 10'($urandom));
    settle();

    repeat (200) issue_mix(40, 35, 20);

    // fill to capacity, then push and read while full
    while (depth < CAPACITY) issue_mix(92, 2, 6);
    send(OP_PUSH_BACK, $urandom, 10'($urandom));
    send(OP_PUSH_FRONT, $urandom, 10'($urandom));
    send(OP_READ, $urandom, 10'h3FF);
    send(OP_READ, $urandom, 10'h000);
    repeat (8) issue_mix(100, 0, 0);
    repeat (8) issue_mix(0, 0, 100);
    settle();

    repeat (150) issue_mix(10, 70, 20);

    settle();
    repeat (10) @(negedge clk);
    if (fails == 0) begin
      $display("double_ended_queue_top: match");
    end else begin
      $display("double_ended_queue_top: mismatch");
    end
    $finish;
  end

endmodule
